@@ hw/rtl/rbd_pkg.sv @@
// Shared types, constants and per-byte arithmetic for the 2x2 RGBA box downscaler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int MAX_OUT_WIDTH    = 512;
    localparam int OUT_HEIGHT_LIMIT = 512;
    localparam int CFG_W            = 10;
    localparam int CFG_IDX_W        = 2;
    localparam int IDX_W            = $clog2(MAX_OUT_WIDTH);
    localparam int COL_W            = IDX_W + 1;
    localparam int ROW_W            = $clog2(2 * OUT_HEIGHT_LIMIT);
    localparam int PIX_W            = 32;
    localparam int SUM_W            = 9;
    localparam int PAIR_W           = 4 * SUM_W;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd1;

    // Position of the incoming source pixel within the image.
    typedef struct packed {
        logic             odd_col;
        logic             odd_row;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_pos;

    // One block ready for averaging: stored upper pair sums and the lower pair sums.
    typedef struct packed {
        logic [PAIR_W-1:0] upper;
        logic [PAIR_W-1:0] lower;
        logic              last;
    } t_blk;

    function automatic logic [PAIR_W-1:0] pair_sums(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        logic [PAIR_W-1:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            r[SUM_W*k +: SUM_W] = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] block_mean(input logic [PAIR_W-1:0] u,
                                                    input logic [PAIR_W-1:0] l);
        logic [PIX_W-1:0] r;
        logic [SUM_W:0]   s;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            s = {1'b0, u[SUM_W*k +: SUM_W]} + {1'b0, l[SUM_W*k +: SUM_W]};
            r[8*k +: 8] = s[SUM_W:2];
        end
        return r;
    endfunction

    // Last source column index (2*w - 1) for an output width register value.
    function automatic logic [COL_W-1:0] col_end(input logic [CFG_W-1:0] v);
        logic [31:0] e;
        if (v == '0) begin
            e = 32'd1;
        end else if (32'(v) > 32'(MAX_OUT_WIDTH)) begin
            e = 32'(MAX_OUT_WIDTH);
        end else begin
            e = 32'(v);
        end
        e = (e << 1) - 32'd1;
        return e[COL_W-1:0];
    endfunction

    // Last source row index (2*h - 1) for an output height register value.
    function automatic logic [ROW_W-1:0] row_end(input logic [CFG_W-1:0] v);
        logic [31:0] e;
        if (v == '0) begin
            e = 32'd1;
        end else if (32'(v) > 32'(OUT_HEIGHT_LIMIT)) begin
            e = 32'(OUT_HEIGHT_LIMIT);
        end else begin
            e = 32'(v);
        end
        e = (e << 1) - 32'd1;
        return e[ROW_W-1:0];
    endfunction

endpackage

@@ hw/rtl/rbd_ctrl.sv @@
// Image size registers and the source column and row counters.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_advance,
    output t_pos                 o_pos
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col_end, n_col_end;
    logic [ROW_W-1:0] r_row_end, n_row_end;
    logic             col_wrap;
    logic             row_wrap;
    logic             cfg_hit;

    assign col_wrap = (r_col == r_col_end);
    assign row_wrap = (r_row == r_row_end);
    assign cfg_hit  = i_cfg_we && ((i_cfg_idx == REG_OUT_WIDTH) ||
                                   (i_cfg_idx == REG_OUT_HEIGHT));

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_col_end = r_col_end;
        n_row_end = r_row_end;
        if (cfg_hit) begin
            // Any size write restarts the image.
            n_col = '0;
            n_row = '0;
            if (i_cfg_idx == REG_OUT_WIDTH) begin
                n_col_end = col_end(i_cfg_data);
            end else begin
                n_row_end = row_end(i_cfg_data);
            end
        end else if (i_advance) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_end <= col_end(CFG_W'(1));
            r_row_end <= row_end(CFG_W'(1));
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_col_end <= n_col_end;
            r_row_end <= n_row_end;
        end
    end

    assign o_pos.odd_col = r_col[0];
    assign o_pos.odd_row = r_row[0];
    assign o_pos.last    = col_wrap && row_wrap;
    assign o_pos.idx     = r_col[COL_W-1:1];

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_col_end)
        else $error("source column beyond the line end");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_row_end)
        else $error("source row beyond the image end");

    a_col_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_cfg_we && col_wrap) |=> (r_col == '0))
        else $error("column counter failed to wrap at the line end");

endmodule

@@ hw/rtl/rbd_line_buf.sv @@
// Left-pixel hold, pair-sum line memory and the first pipeline stage.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_line_buf
    import rbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_pos             i_pos,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_take,
    output logic             o_free,
    output logic             o_vld,
    output t_blk             o_blk
);

    logic [PAIR_W-1:0] mem [MAX_OUT_WIDTH];
    logic [PIX_W-1:0]  r_held;
    logic [PAIR_W-1:0] r_upper;
    logic [PAIR_W-1:0] r_lower;
    logic              r_last;
    logic              r_vld, n_vld;
    logic [PAIR_W-1:0] pair;
    logic              wr_en;
    logic              rd_en;

    assign pair  = pair_sums(r_held, i_pixel);
    assign wr_en = i_accept && i_pos.odd_col && !i_pos.odd_row;
    assign rd_en = i_accept && i_pos.odd_col && i_pos.odd_row;

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_pos.odd_col) begin
            r_held <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_pos.idx] <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_upper <= mem[i_pos.idx];
            r_lower <= pair;
            r_last  <= i_pos.last;
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (rd_en) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_free      = !r_vld || i_take;
    assign o_vld       = r_vld;
    assign o_blk.upper = r_upper;
    assign o_blk.lower = r_lower;
    assign o_blk.last  = r_last;

endmodule

@@ hw/rtl/rbd_avg.sv @@
// Per-byte block mean and the output register of the result channel.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_avg
    import rbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_blk             i_blk,
    input  logic             i_out_stall,
    output logic             o_take,
    output logic             o_out_valid,
    output logic [PIX_W-1:0] o_average_pixel,
    output logic             o_last_pixel
);

    logic             r_vld, n_vld;
    logic [PIX_W-1:0] r_avg;
    logic             r_last;

    assign o_take = i_vld && (!r_vld || !i_out_stall);

    always_comb begin
        n_vld = r_vld;
        if (o_take) begin
            n_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_avg  <= block_mean(i_blk.upper, i_blk.lower);
            r_last <= i_blk.last;
        end
    end

    assign o_out_valid     = r_vld;
    assign o_average_pixel = r_avg;
    assign o_last_pixel    = r_last;

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> o_out_valid)
        else $error("block taken but no result presented");

endmodule

@@ hw/rtl/rgba_box_downscale_2x2.sv @@
// 2x2 box-filter downscaler for RGBA8 pixel streams: top level.
// Pipeline: the line memory read and pair sums are registered at the edge that accepts the
// transaction completing its block, and the mean when the second stage takes that block.
// Throughput: one source pixel per cycle unless the output stalls with both stages full, set
// by the single-port line memory access and the two register stages. Synchronous active-low
// reset clears the counters, both size registers to 1 and all valid flags, not the line memory.
`timescale 1ns / 1ps

// The source image is accepted in raster order. On even rows the left pixel of each
// horizontal pair is held, and the pair's per-byte sums are written into the line memory at
// the pair's column. On odd rows the same pair sums are formed and, together with the line
// memory entry read in the same cycle, passed through a first register stage. The second
// stage adds upper and lower sums per byte, drops the two low bits and presents the result.
// Either size register write restarts the image at its first pixel, so every line memory
// entry is written on an even row before the odd row below reads it.

module rgba_box_downscale_2x2
    import rbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_average_pixel,
    output logic                 o_last_pixel
);

    t_pos pos;
    t_blk blk;
    logic accept;
    logic s1_free;
    logic s1_vld;
    logic take;

    // The input is held off only when both stages are full and the output is stalled.
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;

    rbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (accept),
        .o_pos      (pos)
    );

    rbd_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pos    (pos),
        .i_pixel  (i_pixel),
        .i_take   (take),
        .o_free   (s1_free),
        .o_vld    (s1_vld),
        .o_blk    (blk)
    );

    rbd_avg u_avg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (s1_vld),
        .i_blk           (blk),
        .i_out_stall     (i_out_stall),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .o_average_pixel (o_average_pixel),
        .o_last_pixel    (o_last_pixel)
    );

    // Back-pressure reaches the input only when the whole pipeline is full.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (s1_vld && o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

endmodule

@@ test/rbd_mean_checker.sv @@
// Checker for the 2x2 RGBA box downscaler: follows the size register writes, predicts every
// averaged pixel from the accepted source transactions and compares the output transactions.
// Depends on rbd_pkg for the size limits, widths and register indexes.
`timescale 1ns / 1ps

module rbd_mean_checker
    import rbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [PIX_W-1:0]     i_average_pixel,
    input  logic                 i_last_pixel,
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic [PIX_W-1:0] average;
        logic             last;
    } t_mean;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [10:0]      col_pos;
    logic [10:0]      row_pos;
    logic [PIX_W-1:0] left_pixel;
    // Per-byte sums of each horizontal pair on the even row, one entry per output column.
    logic [3:0][8:0]  upper_sum [MAX_OUT_WIDTH];
    t_mean            mean_queue [$];
    int               mismatches = 0;

    function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
        if (v == '0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        int         w;
        int         h;
        int         slot;
        logic [9:0] total;
        t_mean      m;
        w    = clamp_size(width_reg, MAX_OUT_WIDTH);
        h    = clamp_size(height_reg, OUT_HEIGHT_LIMIT);
        slot = int'(col_pos >> 1);
        m    = '0;
        if (!col_pos[0]) begin
            left_pixel = pix;
        end else if (!row_pos[0]) begin
            for (int k = 0; k < 4; k++) begin
                upper_sum[slot][k] = 9'(left_pixel[8*k +: 8]) + 9'(pix[8*k +: 8]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                total = 10'(upper_sum[slot][k]) + 10'(left_pixel[8*k +: 8])
                      + 10'(pix[8*k +: 8]);
                m.average[8*k +: 8] = total[9:2];
            end
            m.last = (slot == w - 1) && (int'(row_pos >> 1) == h - 1);
            mean_queue.push_back(m);
        end
        col_pos = col_pos + 11'd1;
        if (int'(col_pos) >= 2 * w) begin
            col_pos = '0;
            row_pos = row_pos + 11'd1;
            if (int'(row_pos) >= 2 * h) begin
                row_pos = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_mean want;
        if (!i_rst_n) begin
            width_reg  = CFG_W'(1);
            height_reg = CFG_W'(1);
            col_pos    = '0;
            row_pos    = '0;
            left_pixel = '0;
            mean_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_OUT_WIDTH) begin
                    width_reg = i_cfg_data;
                    col_pos   = '0;
                    row_pos   = '0;
                end else if (i_cfg_idx == REG_OUT_HEIGHT) begin
                    height_reg = i_cfg_data;
                    col_pos    = '0;
                    row_pos    = '0;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_pixel(i_pixel);
            end
            if (i_out_valid && !i_out_stall) begin
                if (mean_queue.size() == 0) begin
                    $display("%0t: unexpected result, average_pixel %h last_pixel %b",
                             $time, i_average_pixel, i_last_pixel);
                    mismatches++;
                end else begin
                    want = mean_queue.pop_front();
                    if (i_average_pixel !== want.average) begin
                        $display("%0t: average_pixel expected %h actual %h",
                                 $time, want.average, i_average_pixel);
                        mismatches++;
                    end
                    if (i_last_pixel !== want.last) begin
                        $display("%0t: last_pixel expected %b actual %b",
                                 $time, want.last, i_last_pixel);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= mean_queue.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ test/tb.sv @@
// Top level of the testbench for the 2x2 RGBA box downscaler: clock, reset, source stimulus,
// receiver stalls and the verdict. Depends on rbd_pkg, rgba_box_downscale_2x2 and
// rbd_mean_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb;
    import rbd_pkg::*;

    // The block has four register slots but only two registers; the upper two must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    // A result leaves through both register stages after its last source transaction; allow a margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 64;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     pixel    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     average_pixel;
    logic                 last_pixel;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   pixels_sent = 0;
    int   pending;
    int   fail_count;

    // A toggle of hold_req asks the receiver process for one long stall.
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;

    always #5 clk = ~clk;

    rgba_box_downscale_2x2 dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_pixel         (pixel),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_average_pixel (average_pixel),
        .o_last_pixel    (last_pixel)
    );

    rbd_mean_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_pixel         (pixel),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_average_pixel (average_pixel),
        .i_last_pixel    (last_pixel),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // Receiver: stalls at random at the current rate, or holds off for a long stretch when
    // asked, so that the block fills up and has to stall its own input.
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Each byte is all zeros, all ones or random, so that saturated sums turn up often.
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] p;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
                0:       p[8*k +: 8] = 8'h00;
                1:       p[8*k +: 8] = 8'hFF;
                default: p[8*k +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    function automatic int fitted_size(input logic [CFG_W-1:0] v, input int hi);
        if (v == '0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Offers one source pixel, after a random idle gap, and returns at the edge at which the
    // transaction is taken. The payload stays put for as long as the block stalls.
    task automatic push_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= pix;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted result has come out. The first edge
    // makes sure the checker has seen the last source transaction before the count is read;
    // the extra cycles cover a pixel that is still in the pipe but makes no result.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write. The enable is lowered again before returning so that two writes in a row
    // never assign it twice within one time step. Only called once the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Sets both sizes (which restarts the image), then sends whole images and, for a broken
    // sequence, part of one more. Now and then the sender pauses in the middle of the image
    // until every result is out; on request the receiver holds off right at the start.
    task automatic run_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int images, input bit broken, input bit long_hold);
        int frame;
        int total;
        int pause_at;
        frame = 4 * fitted_size(w, MAX_OUT_WIDTH) * fitted_size(h, OUT_HEIGHT_LIMIT);
        total = images * frame;
        if (broken) begin
            total += $urandom_range(1, frame - 1);
        end
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : -1;
        settle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_OUT_WIDTH, w);
            write_reg(REG_OUT_HEIGHT, h);
        end else begin
            write_reg(REG_OUT_HEIGHT, h);
            write_reg(REG_OUT_WIDTH, w);
        end
        if (long_hold) begin
            hold_req <= ~hold_req;
        end
        for (int n = 0; n < total; n++) begin
            if (n == pause_at) begin
                settle();
            end
            push_pixel(random_pixel());
        end
        pixels_sent += total;
    endtask

    // One idling regime: a fixed phase that is long enough to fill the block under the long
    // hold-off, then random small sizes until the share of pixels for this regime is sent.
    task automatic run_regime(input int tx_pct, input int rx_pct, input int quota);
        int               goal;
        int               pick;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal        = pixels_sent + quota;
        run_sizes(CFG_W'(4), CFG_W'(2), 2, 1'b0, 1'b1);
        while (pixels_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                w = '0;
            end else if (pick == 1) begin
                w = CFG_W'($urandom_range(7, 16));
            end else begin
                w = CFG_W'($urandom_range(1, 6));
            end
            h = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 3));
            run_sizes(w, h, $urandom_range(1, 2), $urandom_range(0, 3) == 0, 1'b0);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 52;

        // Directed part, starting from the reset sizes of one output pixel per image.
        // All-zero block, then all-ones block where every per-byte sum is at its maximum.
        repeat (4) push_pixel('0);
        repeat (4) push_pixel('1);
        // Mixed bytes whose sums, but for byte 1, are not multiples of four, so truncation shows.
        push_pixel(32'h00FF00FF);
        push_pixel(32'hFF00FF00);
        push_pixel(32'h01010101);
        push_pixel(32'h02030405);
        // Writes to the spare register slots in the middle of an image must change nothing:
        // the two pixels after them still complete the same block.
        repeat (2) push_pixel(random_pixel());
        settle();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, CFG_W'(10'h155));
        repeat (2) push_pixel(random_pixel());
        // A real register write in the middle of an image restarts it; a zero width acts
        // as one output column.
        push_pixel(random_pixel());
        settle();
        write_reg(REG_OUT_WIDTH, '0);
        repeat (4) push_pixel(random_pixel());
        // A zero height acts as one output row.
        settle();
        write_reg(REG_OUT_HEIGHT, '0);
        repeat (4) push_pixel(random_pixel());

        // Random part under the three idling regimes.
        run_regime(16, 52, 250);
        run_regime(52, 16, 250);
        run_regime(0, 0, 250);

        // Widest line: the all-ones width register value is clamped to the largest width, so
        // the second source row starts after 2 * MAX_OUT_WIDTH pixels and its first two
        // blocks complete within the four pixels that follow.
        settle();
        write_reg(REG_OUT_WIDTH, '1);
        write_reg(REG_OUT_HEIGHT, CFG_W'(1));
        repeat (2 * MAX_OUT_WIDTH + 4) push_pixel(random_pixel());

        // Drain, then give any stray result time to show up before the verdict.
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

@@ rgba_box_downscale_2x2.f @@
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_ctrl.sv
hw/rtl/rbd_line_buf.sv
hw/rtl/rbd_avg.sv
hw/rtl/rgba_box_downscale_2x2.sv
test/rbd_mean_checker.sv
test/tb.sv
